FILE: rtl/ttuc_pkg.sv
// Package for the tick/time unit converter: conversion codes, scales and
// pipeline sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ttuc_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned HalfWidth = 32;
    localparam int unsigned FuncWidth = 3;
    localparam int unsigned AddrWidth = 4;

    localparam logic [WordWidth-1:0] ScaleNs = 64'd1000000000;
    localparam logic [WordWidth-1:0] ScaleUs = 64'd1000000;
    localparam logic [WordWidth-1:0] ScaleMs = 64'd1000;

    typedef enum logic [FuncWidth-1:0] {
        FUNC_TICKS_TO_NS = 3'd0,
        FUNC_TICKS_TO_US = 3'd1,
        FUNC_TICKS_TO_MS = 3'd2,
        FUNC_NS_TO_TICKS = 3'd3,
        FUNC_US_TO_TICKS = 3'd4,
        FUNC_MS_TO_TICKS = 3'd5
    } func_t;

endpackage
`default_nettype wire

FILE: rtl/tick_time_unit_converter_core.sv
// An accepted input passes stage A, stage B, the division pipeline and the
// output register. Throughput: one transaction per cycle; the whole pipeline
// holds while a result waits on m_tready, so nothing is dropped or repeated.
// Depth is set by the 64 one-bit restoring division stages, each one 65-bit
// compare and subtract. Synchronous active-low reset clears all valid bits
// and the tick frequency register.
// Depends on ttuc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tick_time_unit_converter_core
    import ttuc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // APB configuration port; register 0 (tick_frequency_hz) at byte 0.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [AddrWidth-1:0] paddr,
    input  wire logic [WordWidth-1:0] pwdata,
    output logic      [WordWidth-1:0] prdata,
    output logic                      pready,
    // Input channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [WordWidth-1:0] s_tdata,  // [63:0] value
    input  wire logic [FuncWidth-1:0] s_tuser,  // [2:0] func
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [WordWidth-1:0] m_tdata,  // [63:0] result
    output logic                      m_tuser   // [0] saturated
);

    localparam int unsigned DivSteps = WordWidth;

    // Configuration register. Writes land on the access phase; the upper
    // address bit selects the register slot, only slot 0 exists.
    logic [WordWidth-1:0] freq_reg;

    assign pready = 1'b1;
    assign prdata = paddr[AddrWidth-1] ? '0 : freq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= '0;
        end else if (psel && penable && pwrite && pready && !paddr[AddrWidth-1]) begin
            freq_reg <= pwdata;
        end
    end

    // One stall signal for the whole pipeline: it moves whenever the output
    // register is empty or being drained.
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // Stage A: operand selection and the four 32x32 partial products.
    logic [WordWidth-1:0] mul_sel, div_sel;
    logic                 en_sel;

    always_comb begin
        mul_sel = '0;
        div_sel = '0;
        case (s_tuser)
            FUNC_TICKS_TO_NS: begin mul_sel = ScaleNs;  div_sel = freq_reg; end
            FUNC_TICKS_TO_US: begin mul_sel = ScaleUs;  div_sel = freq_reg; end
            FUNC_TICKS_TO_MS: begin mul_sel = ScaleMs;  div_sel = freq_reg; end
            FUNC_NS_TO_TICKS: begin mul_sel = freq_reg; div_sel = ScaleNs;  end
            FUNC_US_TO_TICKS: begin mul_sel = freq_reg; div_sel = ScaleUs;  end
            FUNC_MS_TO_TICKS: begin mul_sel = freq_reg; div_sel = ScaleMs;  end
            default: begin mul_sel = '0; div_sel = '0; end
        endcase
        // A zero frequency or an unused code yields a zero result.
        en_sel = (freq_reg != '0) && (div_sel != '0);
    end

    logic                 a_vld_reg, a_en_reg;
    logic [WordWidth-1:0] a_p00_reg, a_p01_reg, a_p10_reg, a_p11_reg, a_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_en_reg  <= en_sel;
            a_d_reg   <= div_sel;
            a_p00_reg <= s_tdata[HalfWidth-1:0]         * mul_sel[HalfWidth-1:0];
            a_p01_reg <= s_tdata[HalfWidth-1:0]         * mul_sel[WordWidth-1:HalfWidth];
            a_p10_reg <= s_tdata[WordWidth-1:HalfWidth] * mul_sel[HalfWidth-1:0];
            a_p11_reg <= s_tdata[WordWidth-1:HalfWidth] * mul_sel[WordWidth-1:HalfWidth];
        end
    end

    // Stage B: sum the partial products into the 128-bit product.
    logic [2*WordWidth-1:0] prod_next;
    assign prod_next = {{WordWidth{1'b0}}, a_p00_reg}
                     + {{HalfWidth{1'b0}}, a_p01_reg, {HalfWidth{1'b0}}}
                     + {{HalfWidth{1'b0}}, a_p10_reg, {HalfWidth{1'b0}}}
                     + {a_p11_reg, {WordWidth{1'b0}}};

    logic                 b_vld_reg, b_en_reg;
    logic [WordWidth-1:0] b_hi_reg, b_lo_reg, b_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_en_reg <= a_en_reg;
            b_d_reg  <= a_d_reg;
            b_hi_reg <= prod_next[2*WordWidth-1:WordWidth];
            b_lo_reg <= prod_next[WordWidth-1:0];
        end
    end

    // Division pipeline. Entry 0 is loaded from stage B together with the
    // overflow check; each further entry retires one quotient bit.
    logic                 dv_vld_reg [0:DivSteps];
    logic                 dv_en_reg  [0:DivSteps];
    logic                 dv_sat_reg [0:DivSteps];
    logic [WordWidth-1:0] dv_rem_reg [0:DivSteps];
    logic [WordWidth-1:0] dv_lo_reg  [0:DivSteps];
    logic [WordWidth-1:0] dv_q_reg   [0:DivSteps];
    logic [WordWidth-1:0] dv_d_reg   [0:DivSteps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_en_reg[0]  <= b_en_reg;
            dv_sat_reg[0] <= b_hi_reg >= b_d_reg;
            dv_rem_reg[0] <= b_hi_reg;
            dv_lo_reg[0]  <= b_lo_reg;
            dv_q_reg[0]   <= '0;
            dv_d_reg[0]   <= b_d_reg;
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        logic [WordWidth:0]   shifted;
        logic [WordWidth:0]   diff;
        logic                 take;
        logic [WordWidth-1:0] rem_next;

        always_comb begin
            shifted  = {dv_rem_reg[k], dv_lo_reg[k][WordWidth-1]};
            diff     = shifted - {1'b0, dv_d_reg[k]};
            take     = !diff[WordWidth];
            rem_next = take ? diff[WordWidth-1:0] : shifted[WordWidth-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_en_reg[k+1]  <= dv_en_reg[k];
                dv_sat_reg[k+1] <= dv_sat_reg[k];
                dv_d_reg[k+1]   <= dv_d_reg[k];
                dv_rem_reg[k+1] <= rem_next;
                dv_lo_reg[k+1]  <= {dv_lo_reg[k][WordWidth-2:0], 1'b0};
                dv_q_reg[k+1]   <= {dv_q_reg[k][WordWidth-2:0], take};
            end
        end
    end

    // Output register: pick zero, saturation or the quotient.
    logic                 out_vld_reg, out_sat_reg;
    logic [WordWidth-1:0] out_res_reg;
    logic [WordWidth-1:0] res_next;
    logic                 sat_next;

    always_comb begin
        if (!dv_en_reg[DivSteps]) begin
            res_next = '0;
            sat_next = 1'b0;
        end else if (dv_sat_reg[DivSteps]) begin
            res_next = '1;
            sat_next = 1'b1;
        end else begin
            res_next = dv_q_reg[DivSteps];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= dv_vld_reg[DivSteps];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_res_reg <= res_next;
            out_sat_reg <= sat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg;
    assign m_tuser  = out_sat_reg;

endmodule
`default_nettype wire
